@@ rtl/core/chd_pkg.sv @@
// shared types and constants for the canonical huffman decoder
`default_nettype none
package chd_pkg;
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_BUILD  = 2'd1,
        CMD_DECODE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_BIT,
        ST_LOOK,
        ST_EMIT
    } state_t;

    localparam int unsigned SymW   = 8;
    localparam int unsigned LenW   = 6;
    localparam int unsigned CodeW  = 32;
    localparam int unsigned OutCntW = 24;
    localparam int unsigned IdxW   = 9;
endpackage
`default_nettype wire

@@ rtl/core/canonical_huffman_decoder.sv @@
// canonical huffman decoder top level: table load, serial build and bit-serial decode
// A load transaction (cmd 0) writes one symbol's length and code; a build transaction
// (cmd 1) sweeps every length against every symbol, one symbol per cycle. A decode
// transaction (cmd 2) shifts its byte out bit by bit, MSB first; each bit is shifted
// into the partial code and then compared against the registered table reads, and a
// matched code then goes through an emit step, which waits while the result side
// stalls. A symbol result is held back until the next symbol or the end of the byte
// shows whether it is the byte's last. One transaction is worked at a time;
// s_axis_tready is high only when the block is idle.
`default_nettype none
module canonical_huffman_decoder
    import chd_pkg::*;
#(
    parameter int unsigned NUM_SYMBOLS  = 256,
    parameter int unsigned MAX_CODE_LEN = 32,
    parameter int unsigned COUNT_WIDTH  = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd[1:0], symbol[9:2], code_length[15:10], code_value[47:16], data_byte[55:48],
    // bit_count[59:56], stream_start[60], zero fill to 64
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // decoded_symbol[7:0], decoded_count[31:8]
    output logic [31:0]      m_axis_tdata,
    // last_of_byte
    output logic             m_axis_tlast
);
    localparam int unsigned SW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int unsigned LW = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
    localparam int unsigned PLW = $clog2(MAX_CODE_LEN + 2);

    logic [1:0]       in_cmd;
    logic [SymW-1:0]  in_sym;
    logic [LenW-1:0]  in_len;
    logic [CodeW-1:0] in_code;
    logic [7:0]       in_byte;
    logic [3:0]       in_cnt;
    logic             in_start;
    assign in_cmd   = s_axis_tdata[1:0];
    assign in_sym   = s_axis_tdata[9:2];
    assign in_len   = s_axis_tdata[15:10];
    assign in_code  = s_axis_tdata[47:16];
    assign in_byte  = s_axis_tdata[55:48];
    assign in_cnt   = s_axis_tdata[59:56];
    assign in_start = s_axis_tdata[60];

    // memories
    logic [LenW-1:0]  len_mem  [NUM_SYMBOLS];
    logic [CodeW-1:0] code_mem [NUM_SYMBOLS];
    logic [SymW-1:0]  sort_mem [NUM_SYMBOLS];
    logic [CodeW-1:0] first_mem [MAX_CODE_LEN];
    logic [CodeW-1:0] last_mem  [MAX_CODE_LEN];
    logic [IdxW-1:0]  base_mem  [MAX_CODE_LEN];
    logic [MAX_CODE_LEN-1:0] used_reg, used_next;
    logic [NUM_SYMBOLS-1:0]  lvalid_reg;

    state_t state_reg, state_next;
    logic [SW:0]        bsym_reg, bsym_next;
    logic [LW:0]        blen_reg, blen_next;
    logic [IdxW-1:0]    n_reg, n_next;
    logic [IdxW-1:0]    total_reg, total_next;
    logic [7:0]         shift_reg, shift_next;
    logic [3:0]         left_reg, left_next;
    logic [CodeW-1:0]   pcode_reg, pcode_next;
    logic [PLW-1:0]     plen_reg, plen_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic               emitted_reg, emitted_next;
    logic [SymW-1:0]    osym_reg, osym_next;
    logic               olast_reg, olast_next;
    logic               ovalid_reg, ovalid_next;
    logic               orel_reg, orel_next;
    logic [OutCntW-1:0] ocnt_reg, ocnt_next;

    // registered reads
    logic [LenW-1:0]  rd_len_reg;
    logic [CodeW-1:0] rd_code_reg;
    logic [SymW-1:0]  rd_sort_reg;
    logic [CodeW-1:0] rd_first_reg, rd_last_reg;
    logic             rd_hit_reg;
    logic             rd_idx_ok_reg;

    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // a held result is shown once it is known whether it is the byte's last
    logic out_go;
    logic emit_go;
    assign m_axis_tvalid = ovalid_reg && (orel_reg || state_reg == ST_EMIT);
    assign out_go        = m_axis_tvalid && m_axis_tready;
    assign emit_go       = !ovalid_reg || out_go;

    logic [LW-1:0] plen_idx;
    assign plen_idx = LW'(plen_reg - PLW'(1));

    logic [LW-1:0] plen_nidx;
    assign plen_nidx = LW'(plen_next - PLW'(1));

    logic [CodeW-1:0] off;
    logic [CodeW:0]   idx_full;
    assign off      = pcode_reg - first_mem[plen_idx];
    assign idx_full = (CodeW+1)'(base_mem[plen_idx]) + (CodeW+1)'(off);

    logic look_ok;
    assign look_ok = (plen_next >= PLW'(1)) && (plen_next <= PLW'(MAX_CODE_LEN))
                     && used_reg[plen_nidx];

    logic idx_ok;
    assign idx_ok = (idx_full < (CodeW+1)'(total_reg))
                    && (idx_full < (CodeW+1)'(NUM_SYMBOLS));

    logic blen_match;
    assign blen_match = (rd_len_reg == LenW'(blen_reg));

    // memory writes and reads
    always_ff @(posedge aclk) begin
        if (in_fire && in_cmd == CMD_LOAD && 32'(in_sym) < NUM_SYMBOLS) begin
            len_mem[SW'(in_sym)]  <= (in_len > LenW'(MAX_CODE_LEN)) ? '0 : in_len;
            code_mem[SW'(in_sym)] <= in_code;
        end
        rd_len_reg  <= lvalid_reg[bsym_reg[SW-1:0]] ? len_mem[bsym_reg[SW-1:0]] : '0;
        rd_code_reg <= code_mem[bsym_reg[SW-1:0]];
        if (state_reg == ST_BUILD && bsym_reg != '0 && blen_match
            && blen_reg <= (LW+1)'(MAX_CODE_LEN)) begin
            sort_mem[n_reg[SW-1:0]] <= SymW'(bsym_reg - (SW+1)'(1));
            if (!used_reg[LW'(blen_reg - (LW+1)'(1))]) begin
                first_mem[LW'(blen_reg - (LW+1)'(1))] <= rd_code_reg;
                base_mem[LW'(blen_reg - (LW+1)'(1))]  <= n_reg;
            end
            last_mem[LW'(blen_reg - (LW+1)'(1))] <= rd_code_reg;
        end
        rd_sort_reg   <= sort_mem[idx_full[SW-1:0]];
        rd_first_reg  <= first_mem[plen_nidx];
        rd_last_reg   <= last_mem[plen_nidx];
        rd_hit_reg    <= look_ok;
        rd_idx_ok_reg <= idx_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvalid_reg <= '0;
        end else if (in_fire && in_cmd == CMD_LOAD && 32'(in_sym) < NUM_SYMBOLS) begin
            lvalid_reg[SW'(in_sym)] <= 1'b1;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && in_cmd == CMD_BUILD) begin
                    state_next = ST_BUILD;
                end else if (in_fire && in_cmd == CMD_DECODE && in_cnt != 4'd0) begin
                    state_next = ST_BIT;
                end
            end
            ST_BUILD: begin
                if (blen_reg == (LW+1)'(MAX_CODE_LEN)
                    && bsym_reg == (SW+1)'(NUM_SYMBOLS)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_BIT:  state_next = ST_LOOK;
            ST_LOOK: begin
                if (rd_hit_reg && pcode_reg >= rd_first_reg && pcode_reg <= rd_last_reg) begin
                    state_next = ST_EMIT;
                end else if (left_reg == 4'd0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_BIT;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    state_next = (left_reg == 4'd0) ? ST_IDLE : ST_BIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        bsym_next    = bsym_reg;
        blen_next    = blen_reg;
        n_next       = n_reg;
        total_next   = total_reg;
        used_next    = used_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        pcode_next   = pcode_reg;
        plen_next    = plen_reg;
        cnt_next     = cnt_reg;
        emitted_next = emitted_reg;
        osym_next    = osym_reg;
        olast_next   = olast_reg;
        ocnt_next    = ocnt_reg;
        ovalid_next  = ovalid_reg && !out_go;
        orel_next    = orel_reg;
        s_axis_tready = (state_reg == ST_IDLE) && !(ovalid_reg && !olast_reg);
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && in_cmd == CMD_BUILD) begin
                    bsym_next = '0;
                    blen_next = (LW+1)'(1);
                    n_next    = '0;
                    used_next = '0;
                end else if (in_fire && in_cmd == CMD_DECODE) begin
                    shift_next   = in_byte;
                    left_next    = (in_cnt > 4'd8) ? 4'd8 : in_cnt;
                    emitted_next = 1'b0;
                    if (in_start) begin
                        pcode_next = '0;
                        plen_next  = '0;
                        cnt_next   = '0;
                    end
                end
            end
            ST_BUILD: begin
                if (bsym_reg != '0 && blen_match) begin
                    used_next[LW'(blen_reg - (LW+1)'(1))] = 1'b1;
                    n_next = n_reg + IdxW'(1);
                end
                if (bsym_reg == (SW+1)'(NUM_SYMBOLS)) begin
                    bsym_next = '0;
                    blen_next = blen_reg + (LW+1)'(1);
                    if (blen_reg == (LW+1)'(MAX_CODE_LEN)) begin
                        total_next = (bsym_reg != '0 && blen_match) ? n_reg + IdxW'(1) : n_reg;
                    end
                end else begin
                    bsym_next = bsym_reg + (SW+1)'(1);
                end
            end
            ST_BIT: begin
                pcode_next = {pcode_reg[CodeW-2:0], shift_reg[7]};
                shift_next = {shift_reg[6:0], 1'b0};
                left_next  = left_reg - 4'd1;
                if (plen_reg <= PLW'(MAX_CODE_LEN)) begin
                    plen_next = plen_reg + PLW'(1);
                end
            end
            ST_LOOK: begin
                if (rd_hit_reg && pcode_reg >= rd_first_reg && pcode_reg <= rd_last_reg) begin
                    if (cnt_reg != '1) begin
                        cnt_next = cnt_reg + COUNT_WIDTH'(1);
                    end
                end else if (left_reg == 4'd0 && emitted_reg && ovalid_reg) begin
                    olast_next = 1'b1;
                    orel_next  = 1'b1;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    osym_next    = rd_idx_ok_reg ? rd_sort_reg : '0;
                    ocnt_next    = OutCntW'(cnt_reg);
                    olast_next   = (left_reg == 4'd0);
                    orel_next    = (left_reg == 4'd0);
                    ovalid_next  = 1'b1;
                    emitted_next = 1'b1;
                    pcode_next   = '0;
                    plen_next    = '0;
                end
            end
            default: ;
        endcase
        if (state_reg == ST_LOOK || state_reg == ST_BIT) begin
            s_axis_tready = 1'b0;
        end
    end

    // last flag on a waiting result is only set while it is still held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            total_reg   <= '0;
            pcode_reg   <= '0;
            plen_reg    <= '0;
            cnt_reg     <= '0;
            ovalid_reg  <= 1'b0;
            orel_reg    <= 1'b0;
            emitted_reg <= 1'b0;
            olast_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            total_reg   <= total_next;
            pcode_reg   <= pcode_next;
            plen_reg    <= plen_next;
            cnt_reg     <= cnt_next;
            ovalid_reg  <= ovalid_next;
            orel_reg    <= orel_next;
            emitted_reg <= emitted_next;
            olast_reg   <= olast_next;
        end
        bsym_reg  <= bsym_next;
        blen_reg  <= blen_next;
        n_reg     <= n_next;
        shift_reg <= shift_next;
        left_reg  <= left_next;
        osym_reg  <= osym_next;
        ocnt_reg  <= ocnt_next;
    end

    assign m_axis_tdata  = {ocnt_reg, osym_reg};
    assign m_axis_tlast  = olast_reg;

    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_axis_tready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    property p_plen_bound;
        @(posedge aclk) disable iff (!aresetn)
        plen_reg <= PLW'(MAX_CODE_LEN + 1);
    endproperty
    a_plen_bound: assert property (p_plen_bound) else $error("code length overrun");

    property p_emit_clears;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && emit_go) |=> (plen_reg == '0);
    endproperty
    a_emit_clears: assert property (p_emit_clears) else $error("code not cleared");
endmodule
`default_nettype wire

@@ bench/canonical_huffman_decoder_tb.sv @@
// self-checking testbench for the canonical huffman decoder: table loads, builds and byte decodes
`timescale 1ns / 100ps
module canonical_huffman_decoder_tb;
    import chd_pkg::*;

    typedef struct {
        bit          drain;
        logic [63:0] d;
    } stim_t;

    typedef struct {
        logic [7:0]  sym;
        logic        last;
        logic [23:0] count;
    } sym_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    canonical_huffman_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 aclk = ~aclk;

    stim_t       pending_items[$];
    sym_result_t expected_syms[$];
    int          errors = 0;
    int          items_sent = 0;
    int          syms_seen = 0;
    int          builds_done = 0;

    // decoder model state
    logic [5:0]  len_tab [256];
    logic [31:0] code_tab [256];
    logic [7:0]  sorted_tab [256];
    logic [31:0] first_tab [32];
    logic [31:0] last_tab [32];
    logic [8:0]  base_tab [32];
    bit          used_tab [32];
    logic [31:0] cur_code = '0;
    logic [5:0]  cur_len = '0;
    logic [23:0] sym_count = '0;
    int          sorted_cnt = 0;

    initial begin
        for (int i = 0; i < 256; i++) begin
            len_tab[i] = '0;
            code_tab[i] = '0;
            sorted_tab[i] = '0;
        end
        for (int i = 0; i < 32; i++) begin
            first_tab[i] = '0;
            last_tab[i] = '0;
            base_tab[i] = '0;
            used_tab[i] = 1'b0;
        end
    end

    task automatic build_decode_tables();
        int n;
        n = 0;
        for (int l = 1; l <= 32; l++) begin
            used_tab[l-1] = 1'b0;
            for (int s = 0; s < 256; s++) begin
                if (len_tab[s] == l) begin
                    if (!used_tab[l-1]) begin
                        used_tab[l-1] = 1'b1;
                        first_tab[l-1] = code_tab[s];
                        base_tab[l-1] = n[8:0];
                    end
                    last_tab[l-1] = code_tab[s];
                    sorted_tab[n & 255] = s[7:0];
                    n++;
                end
            end
        end
        sorted_cnt = n;
    endtask

    task automatic decode_transaction(logic [63:0] d);
        cmd_t        c;
        logic [7:0]  dbyte;
        int          nb;
        int          first_new;
        int          l;
        longint      idx;
        sym_result_t r;
        c = cmd_t'(d[1:0]);
        dbyte = d[55:48];
        nb = d[59:56];
        first_new = expected_syms.size();
        case (c)
            CMD_LOAD: begin
                len_tab[d[9:2]] = (d[15:10] > 32) ? 6'd0 : d[15:10];
                code_tab[d[9:2]] = d[47:16];
            end
            CMD_BUILD: begin
                build_decode_tables();
                builds_done++;
            end
            CMD_DECODE: begin
                if (d[60]) begin
                    cur_code = '0;
                    cur_len = '0;
                    sym_count = '0;
                end
                if (nb > 8) nb = 8;
                for (int i = 0; i < nb; i++) begin
                    cur_code = {cur_code[30:0], dbyte[7-i]};
                    if (cur_len <= 32) cur_len++;
                    l = cur_len;
                    if (l >= 1 && l <= 32 && used_tab[l-1] && cur_code >= first_tab[l-1]
                            && cur_code <= last_tab[l-1]) begin
                        idx = longint'(base_tab[l-1]) + longint'(cur_code - first_tab[l-1]);
                        r.sym = (idx < sorted_cnt && idx < 256) ? sorted_tab[idx] : 8'd0;
                        if (sym_count != 24'hFFFFFF) sym_count++;
                        r.last = 1'b0;
                        r.count = sym_count;
                        expected_syms.push_back(r);
                        cur_code = '0;
                        cur_len = '0;
                    end
                end
                if (expected_syms.size() > first_new)
                    expected_syms[expected_syms.size()-1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // input side: prediction on each accepted transaction
    logic in_acc = 1'b0;
    always @(posedge aclk) begin
        in_acc <= s_axis_tvalid && s_axis_tready && aresetn;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            decode_transaction(s_axis_tdata);
            items_sent++;
        end
    end

    // driver
    int gap = 0;
    always @(negedge aclk) begin
        if (aresetn && !(s_axis_tvalid && !in_acc)) begin
            if (gap > 0) begin
                gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (pending_items[0].drain) begin
                s_axis_tvalid <= 1'b0;
                if (expected_syms.size() == 0) void'(pending_items.pop_front());
            end else begin
                s_axis_tdata <= pending_items.pop_front().d;
                s_axis_tvalid <= 1'b1;
                if (pending_items.size() > 40 && $urandom_range(0, 5) == 0)
                    gap = $urandom_range(1, 13);
            end
        end
    end

    // receiver with stall bursts and one long hold-off
    int  stall = 0;
    int  hold_cnt = 0;
    bit  long_done = 1'b0;
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (!long_done && syms_seen >= 100) begin
            long_done = 1'b1;
            hold_cnt = 400;
            m_axis_tready <= 1'b0;
        end else if (stall > 0) begin
            stall--;
            m_axis_tready <= 1'b0;
        end else if (pending_items.size() > 40 && $urandom_range(0, 6) == 0) begin
            stall = $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        sym_result_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            syms_seen++;
            if (expected_syms.size() == 0) begin
                report_mismatch($sformatf("unexpected symbol %0d", m_axis_tdata[7:0]));
            end else begin
                e = expected_syms.pop_front();
                if (m_axis_tdata[7:0] !== e.sym)
                    report_mismatch($sformatf("symbol %0d, want %0d", m_axis_tdata[7:0], e.sym));
                if (m_axis_tlast !== e.last)
                    report_mismatch($sformatf("last_of_byte %b, want %b", m_axis_tlast, e.last));
                if (m_axis_tdata[31:8] !== e.count)
                    report_mismatch($sformatf("count %0d, want %0d", m_axis_tdata[31:8], e.count));
            end
        end
    end

    // stimulus generation
    int          gen_len [256];
    logic [31:0] gen_code [256];
    int          gen_syms[$];

    function automatic logic [63:0] pack_item(cmd_t c, logic [7:0] sym, logic [5:0] len,
            logic [31:0] code, logic [7:0] dbyte, logic [3:0] nb, logic st);
        return {3'b000, st, nb, dbyte, code, len, sym, c};
    endfunction

    task automatic push_item(logic [63:0] d);
        stim_t t;
        t.drain = 1'b0;
        t.d = d;
        pending_items.push_back(t);
    endtask

    task automatic push_drain();
        stim_t t;
        t.drain = 1'b1;
        t.d = '0;
        pending_items.push_back(t);
    endtask

    task automatic push_load(int sym, int len, logic [31:0] code);
        gen_len[sym] = (len > 32) ? 0 : len;
        gen_code[sym] = code;
        push_item(pack_item(CMD_LOAD, sym[7:0], len[5:0], code, 8'($urandom), 4'($urandom),
                            1'($urandom)));
    endtask

    task automatic push_byte(logic [7:0] b, int nb, bit st);
        push_item(pack_item(CMD_DECODE, 8'($urandom), 6'($urandom), $urandom, b, nb[3:0], st));
    endtask

    task automatic push_build();
        push_drain();
        push_item(pack_item(CMD_BUILD, 8'($urandom), 6'($urandom), $urandom, 8'($urandom),
                            4'($urandom), 1'($urandom)));
    endtask

    task automatic push_junk();
        push_item(pack_item(CMD_NONE, 8'($urandom), 6'($urandom), $urandom, 8'($urandom),
                            4'($urandom), 1'($urandom)));
    endtask

    task automatic clear_table();
        for (int s = 0; s < 256; s++)
            if (gen_len[s] != 0)
                push_load(s, $urandom_range(0, 1) ? 0 : $urandom_range(33, 63), $urandom);
    endtask

    task automatic make_table(int k, bit deep);
        int          d[$];
        int          perm[256];
        int          j;
        int          tmp;
        logic [31:0] code;
        clear_table();
        if (deep) begin
            for (int l = 1; l <= 32; l++) d.push_back(l);
            d.push_back(32);
        end else begin
            d = '{1, 1};
            repeat (k - 2) begin
                j = $urandom_range(0, d.size() - 1);
                if (d[j] < 32) begin
                    d[j]++;
                    d.push_back(d[j]);
                end
            end
        end
        for (int i = 0; i < 256; i++) perm[i] = i;
        for (int i = 255; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < d.size(); i++) gen_len[perm[i]] = d[i];
        code = '0;
        for (int l = 1; l <= 32; l++) begin
            code = code << 1;
            for (int s = 0; s < 256; s++)
                if (gen_len[s] == l) begin
                    gen_code[s] = code;
                    code++;
                end
        end
        gen_syms.delete();
        for (int i = 0; i < d.size(); i++) begin
            gen_syms.push_back(perm[i]);
            push_load(perm[i], gen_len[perm[i]], gen_code[perm[i]]);
        end
        push_build();
    endtask

    task automatic make_stream(int nsym);
        bit         bits[$];
        int         s;
        int         nb;
        int         bc;
        logic [7:0] b;
        bit         first;
        first = 1'b1;
        repeat (nsym) begin
            s = gen_syms[$urandom_range(0, gen_syms.size() - 1)];
            for (int i = gen_len[s] - 1; i >= 0; i--) bits.push_back(gen_code[s][i]);
        end
        while (bits.size() > 0) begin
            nb = $urandom_range(1, 8);
            b = 8'($urandom);
            for (int i = 0; i < nb; i++)
                b[7-i] = (bits.size() > 0) ? bits.pop_front() : 1'($urandom_range(0, 1));
            bc = (nb == 8 && $urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : nb;
            push_byte(b, bc, first);
            first = 1'b0;
            case ($urandom_range(0, 19))
                0: push_junk();
                1: push_byte(8'($urandom), 0, 1'b0);
                default: ;
            endcase
        end
    endtask

    initial begin
        for (int i = 0; i < 256; i++) begin
            gen_len[i] = 0;
            gen_code[i] = '0;
        end
        // directed: idle commands, loads before any build, oversized lengths
        push_junk();
        push_load(255, 63, 32'hFFFF_FFFF);
        push_byte(8'hA5, 8, 1'b1);
        // lengths 1, 2, 3, 3
        push_load(0, 1, 32'd0);
        push_load(255, 2, 32'd2);
        push_load(7, 3, 32'd6);
        push_load(9, 3, 32'd7);
        push_build();
        push_byte(8'h00, 8, 1'b1);
        push_byte(8'hFF, 15, 1'b0);
        push_byte(8'hDB, 0, 1'b0);
        push_byte(8'hB6, 5, 1'b0);
        // non-canonical range that runs past the sorted list
        push_load(0, 0, 32'd0);
        push_load(255, 40, 32'd0);
        push_load(7, 0, 32'd0);
        push_load(9, 0, 32'd0);
        push_load(3, 2, 32'd0);
        push_load(4, 2, 32'd3);
        push_build();
        push_byte(8'h1B, 8, 1'b1);
        // code that never completes, then a restart
        push_load(3, 0, 32'd0);
        push_load(4, 5, 32'd31);
        push_build();
        repeat (5) push_byte(8'h00, 8, 1'b0);
        push_byte(8'hFC, 8, 1'b1);
        // random tables, one of them with codes down to 32 bits
        make_table(0, 1'b1);
        make_stream(12);
        for (int r = 0; r < 4; r++) begin
            make_table($urandom_range(2, 24), 1'b0);
            make_stream($urandom_range(20, 35));
        end
        make_table(3, 1'b0);
        make_stream(60);

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_syms.size() != 0);
        repeat (200) @(posedge aclk);
        if (expected_syms.size() != 0) report_mismatch("symbols still outstanding at end");
        $display("covered %0d transactions and %0d table builds, %0d decoded symbols checked",
                 items_sent, builds_done, syms_seen);
        if (errors == 0) begin
            $display("canonical_huffman_decoder_tb: PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("canonical_huffman_decoder_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout");
        $display("canonical_huffman_decoder_tb: FAIL");
        $finish;
    end
endmodule
